// ===== design/q2e_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared constants, types and tables for the quaternion to Z-Y-X Euler
// angle pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

    // format of the quaternion fields and of the output angles
    localparam int QUAT_FRAC_BITS = 14;
    localparam int ANGLE_WIDTH    = 16;
    localparam int CORDIC_STAGES  = 16;
    localparam int QW             = 16;

    // products and atan2 arguments
    localparam int FRAC2  = 2 * QUAT_FRAC_BITS;
    localparam int ARG_W  = 2 * QW + 2;

    // square root datapath, operand fixed at 30 fraction bits
    localparam int U_BITS     = 30;
    localparam int T_W        = 2 * U_BITS + 1;
    localparam int R_W        = T_W + 1;
    localparam int ROOT_W     = U_BITS + 1;
    localparam int SQRT_STEPS = U_BITS + 1;
    localparam int PRE_STEPS  = 3;
    localparam int ISQRT_LAT  = PRE_STEPS + SQRT_STEPS;

    // cordic datapath
    localparam int NORM_TOP   = 40;
    localparam int NORM_STEPS = 6;
    localparam int CW         = NORM_TOP + 4;
    localparam int Z_W        = 32;
    localparam int CORDIC_LAT = 1 + NORM_STEPS + CORDIC_STAGES;

    // stream word widths
    localparam int IN_TDATA_W  = ((4 * QW + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * ANGLE_WIDTH + 7) / 8) * 8;

    // turn constants
    localparam logic [Z_W-1:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [Z_W-1:0] TURN_THREEQ  = 32'hC000_0000;

    // output rounding
    localparam int ROUND_SH = Z_W - ANGLE_WIDTH;
    localparam logic [Z_W:0] ROUND_ADD =
        (ROUND_SH > 0) ? ((Z_W + 1)'(1) << (ROUND_SH - 1)) : '0;

    // saturated pitch code, +pi/2
    localparam logic signed [ANGLE_WIDTH-1:0] PITCH_MAX =
        ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

    typedef logic signed [ARG_W-1:0] t_arg;
    typedef logic [Z_W-1:0]          t_turn;

    typedef struct packed {
        t_arg sr;
        t_arg cr;
        t_arg sy;
        t_arg cy;
        t_arg sp;
    } t_front;

    typedef struct packed {
        logic clamp;
        logic neg;
    } t_ptag;

    typedef struct packed {
        t_turn roll;
        t_turn yaw;
    } t_ry;

    typedef struct packed {
        logic                          clamp;
        logic signed [ANGLE_WIDTH-1:0] yaw;
        logic signed [ANGLE_WIDTH-1:0] pitch;
        logic signed [ANGLE_WIDTH-1:0] roll;
    } t_result;

    // atan(2^-k) in turns of 2^32
    localparam logic [Z_W-1:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // round half up to the output angle width
    function automatic logic [ANGLE_WIDTH-1:0] to_out(input t_turn a);
        logic [Z_W:0] v;
        v = {1'b0, a} + ROUND_ADD;
        return v[ROUND_SH +: ANGLE_WIDTH];
    endfunction

endpackage
`default_nettype wire

// ===== design/quaternion_to_euler_zyx_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_zyx_top
// Unit quaternion in Q1.14 to roll, pitch and yaw binary angles (Z-Y-X).
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the skid entry is empty; every stage is one register step
// the pitch path sets the latency: 31 square root stages plus the cordic
// a two-entry output buffer lets one more word enter while a result waits
// reset: synchronous, active low, clears all valid bits; no memories to clear
module quaternion_to_euler_zyx_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z
    input  wire logic [q2e_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // roll_angle, pitch_angle, yaw_angle
    output logic [q2e_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // pitch_clamped
    output logic [0:0]                             o_m_axis_tuser
);
    import q2e_pkg::*;

    logic    w_en, w_push;
    logic    w_fv;
    t_front  w_front;
    logic    w_sv;
    t_ptag   w_stag;
    logic [U_BITS-1:0] w_m30;
    logic [ROOT_W-1:0] w_root;
    logic    w_pv;
    t_ptag   w_ptag;
    t_turn   w_pturn, w_pz;
    t_ry     w_ry, w_ry_d;

    logic    r_fin_v, r_out_v, r_skid_v;
    t_result r_fin, r_out, r_skid;

    assign w_en            = !r_skid_v;
    assign w_push          = w_en && r_fin_v;
    assign o_s_axis_tready = w_en;

    // products and arguments
    q2e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_w     ($signed(i_s_axis_tdata[QW-1:0])),
        .i_x     ($signed(i_s_axis_tdata[2*QW-1:QW])),
        .i_y     ($signed(i_s_axis_tdata[3*QW-1:2*QW])),
        .i_z     ($signed(i_s_axis_tdata[4*QW-1:3*QW])),
        .o_valid (w_fv),
        .o_front (w_front)
    );

    // roll and yaw
    q2e_cordic u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_tag   ('0),
        .i_y     (w_front.sr),
        .i_x     (w_front.cr),
        .o_valid (),
        .o_tag   (),
        .o_turn  (w_ry.roll)
    );

    q2e_cordic u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_tag   ('0),
        .i_y     (w_front.sy),
        .i_x     (w_front.cy),
        .o_valid (),
        .o_tag   (),
        .o_turn  (w_ry.yaw)
    );

    q2e_delay u_delay (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (w_ry),
        .o_data (w_ry_d)
    );

    // pitch: sine and cosine, then atan2
    q2e_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_sp    (w_front.sp),
        .o_valid (w_sv),
        .o_tag   (w_stag),
        .o_m30   (w_m30),
        .o_root  (w_root)
    );

    q2e_cordic u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sv),
        .i_tag   (w_stag),
        .i_y     (ARG_W'(w_m30)),
        .i_x     (ARG_W'(w_root)),
        .o_valid (w_pv),
        .o_tag   (w_ptag),
        .o_turn  (w_pturn)
    );

    // saturation and sign of pitch
    always_comb begin
        w_pz = w_ptag.clamp ? TURN_QUARTER : w_pturn;
        if (w_ptag.neg) begin
            w_pz = -w_pz;
        end
    end

    // final stage: rounding to output width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (w_en) begin
            r_fin_v <= w_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin.roll  <= to_out(w_ry_d.roll);
            r_fin.yaw   <= to_out(w_ry_d.yaw);
            r_fin.pitch <= to_out(w_pz);
            r_fin.clamp <= w_ptag.clamp;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_axis_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= w_push;
            end
        end else if (w_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_axis_tready) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (w_push) begin
                r_out <= r_fin;
            end
        end else if (w_push) begin
            r_skid <= r_fin;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out.yaw, r_out.pitch, r_out.roll});
    assign o_m_axis_tuser  = r_out.clamp;

`ifndef ASSERT_OFF
    // skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry full while output register empty");

    // skid entry fills only from a finished word
    a_skid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_fin_v))
        else $error("skid entry filled without a finished word");

    // frozen pipeline keeps its last stage
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_fin_v))
        else $error("pipeline moved while stalled");

    // clamp flag comes only with a saturated pitch
    a_clamp_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.clamp) |-> (r_out.pitch == PITCH_MAX
                                      || r_out.pitch == -PITCH_MAX))
        else $error("clamp flag without saturated pitch");
`endif

endmodule
`default_nettype wire

// ===== design/q2e_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_front
// Products of the quaternion components and the five atan2 / asin
// arguments, two register stages.
// ----------------------------------------------------------------------------
module q2e_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic signed [q2e_pkg::QW-1:0] i_w,
    input  wire logic signed [q2e_pkg::QW-1:0] i_x,
    input  wire logic signed [q2e_pkg::QW-1:0] i_y,
    input  wire logic signed [q2e_pkg::QW-1:0] i_z,
    output logic                            o_valid,
    output q2e_pkg::t_front                 o_front
);
    import q2e_pkg::*;

    localparam int PW = 2 * QW;
    localparam t_arg ONE = ARG_W'(1) << FRAC2;

    logic r_v1;
    logic r_v2;
    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    t_front r_front;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= i_w * i_x;
            r_yz <= i_y * i_z;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_wz <= i_w * i_z;
            r_xy <= i_x * i_y;
            r_zz <= i_z * i_z;
            r_wy <= i_w * i_y;
            r_zx <= i_z * i_x;
        end
    end

    // stage 2: doubled sums and difference; cosine arguments as one minus a doubled sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front.sr <= (ARG_W'(r_wx) + ARG_W'(r_yz)) <<< 1;
            r_front.cr <= ONE - ((ARG_W'(r_xx) + ARG_W'(r_yy)) <<< 1);
            r_front.sy <= (ARG_W'(r_wz) + ARG_W'(r_xy)) <<< 1;
            r_front.cy <= ONE - ((ARG_W'(r_yy) + ARG_W'(r_zz)) <<< 1);
            r_front.sp <= (ARG_W'(r_wy) - ARG_W'(r_zx)) <<< 1;
        end
    end

    assign o_valid = r_v2;
    assign o_front = r_front;

endmodule
`default_nettype wire

// ===== design/q2e_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pitch argument conditioning: saturation test, scaling to 30 fraction bits
// and the floor square root of 1 - s^2, one result bit per stage.
// ----------------------------------------------------------------------------
module q2e_isqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire q2e_pkg::t_arg                 i_sp,
    output logic                               o_valid,
    output q2e_pkg::t_ptag                     o_tag,
    output logic [q2e_pkg::U_BITS-1:0]         o_m30,
    output logic [q2e_pkg::ROOT_W-1:0]         o_root
);
    import q2e_pkg::*;

    localparam int SH_R = (FRAC2 >= U_BITS) ? FRAC2 - U_BITS : 0;
    localparam int SH_L = (FRAC2 >= U_BITS) ? 0 : U_BITS - FRAC2;
    localparam int EXT_W = ARG_W + U_BITS;

    logic [ARG_W-1:0]   w_mp;
    logic [EXT_W-1:0]   w_ext;
    logic               r_va, r_vb;
    t_ptag              r_taga, r_tagb;
    logic [U_BITS-1:0]  r_ma, r_mb;
    logic [2*U_BITS-1:0] r_sq;

    logic               r_v   [0:SQRT_STEPS];
    t_ptag              r_tag [0:SQRT_STEPS];
    logic [U_BITS-1:0]  r_m   [0:SQRT_STEPS];
    logic [T_W-1:0]     r_t   [0:SQRT_STEPS];
    logic [R_W-1:0]     r_r   [0:SQRT_STEPS];

    // magnitude and scaling of the argument
    assign w_mp  = i_sp[ARG_W-1] ? ARG_W'(-i_sp) : ARG_W'(i_sp);
    assign w_ext = (EXT_W'(w_mp) >> SH_R) << SH_L;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            for (int j = 0; j <= SQRT_STEPS; j++) begin
                r_v[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_v[0] <= r_vb;
            for (int j = 1; j <= SQRT_STEPS; j++) begin
                r_v[j] <= r_v[j-1];
            end
        end
    end

    // stages a to c: saturation, square, radicand
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_taga.clamp <= (w_mp >= (ARG_W'(1) << FRAC2));
            r_taga.neg   <= i_sp[ARG_W-1];
            r_ma         <= w_ext[U_BITS-1:0];
            r_tagb       <= r_taga;
            r_mb         <= r_ma;
            r_sq         <= r_ma * r_ma;
            r_tag[0]     <= r_tagb;
            r_m[0]       <= r_mb;
            r_t[0]       <= (T_W'(1) << (2 * U_BITS)) - T_W'(r_sq);
            r_r[0]       <= '0;
        end
    end

    // root stages, one bit each, highest bit first
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        localparam int K = SQRT_STEPS - 1 - j;
        localparam logic [R_W-1:0] BIT = R_W'(1) << (2 * K);
        logic [R_W-1:0] w_sum;
        logic           w_ge;

        assign w_sum = r_r[j] + BIT;
        assign w_ge  = (R_W'(r_t[j]) >= w_sum);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[j+1] <= r_tag[j];
                r_m[j+1]   <= r_m[j];
                if (w_ge) begin
                    r_t[j+1] <= T_W'(R_W'(r_t[j]) - w_sum);
                    r_r[j+1] <= (r_r[j] >> 1) + BIT;
                end else begin
                    r_t[j+1] <= r_t[j];
                    r_r[j+1] <= r_r[j] >> 1;
                end
            end
        end
    end

    assign o_valid = r_v[SQRT_STEPS];
    assign o_tag   = r_tag[SQRT_STEPS];
    assign o_m30   = r_m[SQRT_STEPS];
    assign o_root  = r_r[SQRT_STEPS][ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== design/q2e_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined atan2 in vectoring mode: quadrant turn, normalization of the
// vector to a fixed magnitude window, then one rotation per stage.
// ----------------------------------------------------------------------------
module q2e_cordic (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire q2e_pkg::t_ptag i_tag,
    input  wire q2e_pkg::t_arg  i_y,
    input  wire q2e_pkg::t_arg  i_x,
    output logic                o_valid,
    output q2e_pkg::t_ptag      o_tag,
    output q2e_pkg::t_turn      o_turn
);
    import q2e_pkg::*;

    localparam int LAT = CORDIC_LAT;

    logic signed [CW-1:0] w_x, w_y, w_px, w_py, w_ay;
    t_turn                w_pz;
    logic [CW-1:0]        w_m;

    logic                 r_v    [LAT];
    t_ptag                r_tag  [LAT];
    logic                 r_zero [LAT];
    logic signed [CW-1:0] r_x    [LAT];
    logic signed [CW-1:0] r_y    [LAT];
    t_turn                r_z    [LAT];
    logic [NORM_TOP-1:0]  r_m    [NORM_STEPS];

    // quadrant turn so that x is not negative
    assign w_x = CW'(i_x);
    assign w_y = CW'(i_y);
    always_comb begin
        if (w_x < 0) begin
            if (w_y >= 0) begin
                w_px = w_y;
                w_py = -w_x;
                w_pz = TURN_QUARTER;
            end else begin
                w_px = -w_y;
                w_py = w_x;
                w_pz = TURN_THREEQ;
            end
        end else begin
            w_px = w_x;
            w_py = w_y;
            w_pz = '0;
        end
    end
    assign w_ay = (w_py < 0) ? -w_py : w_py;
    assign w_m  = w_px | w_ay;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < LAT; g++) begin
                r_v[g] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int g = 1; g < LAT; g++) begin
                r_v[g] <= r_v[g-1];
            end
        end
    end

    // stage 0: turned vector
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0]  <= i_tag;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            r_x[0]    <= w_px;
            r_y[0]    <= w_py;
            r_z[0]    <= w_pz;
            r_m[0]    <= w_m[NORM_TOP-1:0];
        end
    end

    for (genvar g = 1; g < LAT; g++) begin : g_stage
        // side data follows the vector
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[g]  <= r_tag[g-1];
                r_zero[g] <= r_zero[g-1];
            end
        end

        if (g <= NORM_STEPS) begin : g_norm
            // normalize: leading one of the magnitude into the top bit
            localparam int S = 1 << (NORM_STEPS - g);
            logic w_go;
            assign w_go = (r_m[g-1][NORM_TOP-1 -: S] == '0);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[g] <= w_go ? (r_x[g-1] <<< S) : r_x[g-1];
                    r_y[g] <= w_go ? (r_y[g-1] <<< S) : r_y[g-1];
                    r_z[g] <= r_z[g-1];
                end
            end

            if (g < NORM_STEPS) begin : g_mag
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_m[g] <= w_go ? (r_m[g-1] << S) : r_m[g-1];
                    end
                end
            end
        end else begin : g_rot
            // one vectoring rotation
            localparam int K = (g - 1 - NORM_STEPS) % 32;
            logic signed [CW-1:0] w_dx, w_dy;
            assign w_dx = r_y[g-1] >>> K;
            assign w_dy = r_x[g-1] >>> K;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_y[g-1][CW-1]) begin
                        r_x[g] <= r_x[g-1] + w_dx;
                        r_y[g] <= r_y[g-1] - w_dy;
                        r_z[g] <= r_z[g-1] + ATAN_TAB[K];
                    end else begin
                        r_x[g] <= r_x[g-1] - w_dx;
                        r_y[g] <= r_y[g-1] + w_dy;
                        r_z[g] <= r_z[g-1] - ATAN_TAB[K];
                    end
                end
            end
        end
    end

    assign o_valid = r_v[LAT-1];
    assign o_tag   = r_tag[LAT-1];
    assign o_turn  = r_zero[LAT-1] ? '0 : r_z[LAT-1];

endmodule
`default_nettype wire

// ===== design/q2e_delay.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_delay
// Shift line that holds the roll and yaw angles while pitch goes through
// the square root stages.
// ----------------------------------------------------------------------------
module q2e_delay (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire q2e_pkg::t_ry i_data,
    output q2e_pkg::t_ry      o_data
);
    import q2e_pkg::*;

    localparam int DEPTH = ISQRT_LAT;

    t_ry r_pipe [DEPTH];

    // shift on every enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_data = r_pipe[DEPTH-1];

endmodule
`default_nettype wire
